// ===== hdl/ecsv_pkg.sv =====
// ----------------------------------------------------------------------------
// ecsv_pkg
// Shared types and constants of the event CSV line tokenizer.
// ----------------------------------------------------------------------------
package ecsv_pkg;

    // Fixed field widths of a result word
    localparam int SPAN_START_W = 10;
    localparam int SPAN_END_W   = 11;

    // Result queue depth: room for two words per byte plus drain slack
    localparam int FIFO_DEPTH = 4;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    typedef enum logic [2:0] {
        KIND_NAME   = 3'd0,
        KIND_TS     = 3'd1,
        KIND_KEY    = 3'd2,
        KIND_VALUE  = 3'd3,
        KIND_STATUS = 3'd4
    } token_kind_t;

    typedef enum logic [2:0] {
        VK_NULL   = 3'd0,
        VK_BOOL   = 3'd1,
        VK_INT    = 3'd2,
        VK_REAL   = 3'd3,
        VK_STRING = 3'd4
    } value_kind_t;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_UNEXPECTED_END = 3'd1,
        ST_TOO_MANY_PAIRS = 3'd2,
        ST_TOO_LONG       = 3'd3,
        ST_COUNT_MISMATCH = 3'd4
    } line_status_t;

    typedef struct packed {
        token_kind_t              token_kind;
        logic [SPAN_START_W-1:0]  span_start;
        logic [SPAN_END_W-1:0]    span_end;
        value_kind_t              value_kind;
        logic                     bool_value;
        line_status_t             line_status;
        logic                     last;
    } result_t;

    // Line tracker to value typer
    typedef struct packed {
        logic       clear;   // new line: drop all typing state
        logic       start;   // value opens with this byte
        logic       step;    // type this byte
        logic [7:0] c;
        logic       ws;
    } typer_ctl_t;

    // Value typer to line tracker
    typedef struct packed {
        value_kind_t kind;
        logic        bool_seen;
    } typer_stat_t;

endpackage

// ===== hdl/ecsv_in_if.sv =====
// ----------------------------------------------------------------------------
// ecsv_in_if
// Character channel: one byte of a log line per word.
// ----------------------------------------------------------------------------
interface ecsv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

// ===== hdl/ecsv_out_if.sv =====
// ----------------------------------------------------------------------------
// ecsv_out_if
// Token channel: one field span or line status per word.
// ----------------------------------------------------------------------------
interface ecsv_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [9:0]  span_start;
    logic [10:0] span_end;
    logic [2:0]  value_kind;
    logic        bool_value;
    logic [2:0]  line_status;
    logic        last;

    modport source (
        output valid, output token_kind, output span_start, output span_end,
        output value_kind, output bool_value, output line_status, output last,
        input ready
    );
    modport sink (
        input valid, input token_kind, input span_start, input span_end,
        input value_kind, input bool_value, input line_status, input last,
        output ready
    );
endinterface

// ===== hdl/ecsv_value_typer.sv =====
// ----------------------------------------------------------------------------
// ecsv_value_typer
// Classifies the value under way as null, boolean, integer, real or string.
// ----------------------------------------------------------------------------
module ecsv_value_typer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ecsv_pkg::typer_ctl_t ctl,
    output ecsv_pkg::typer_stat_t stat
);
    import ecsv_pkg::*;

    typedef enum logic [3:0] {
        VC_UNKNOWN,
        VC_INT,
        VC_ZERO,
        VC_REAL,
        VC_NEG,
        VC_STRING,
        VC_T,
        VC_TR,
        VC_TRU,
        VC_F,
        VC_FA,
        VC_FAL,
        VC_FALS,
        VC_TRAIL
    } vclass_t;

    vclass_t     vc_reg, vc_next, vc_base;
    value_kind_t vt_reg, vt_next, vt_base;
    logic        bool_reg, bool_next;
    logic        dig;

    always_comb
    begin
        dig = ctl.c inside {[CH_ZERO:CH_NINE]};
        vc_base = ctl.start ? VC_UNKNOWN : vc_reg;
        vt_base = ctl.start ? VK_NULL : vt_reg;
        vc_next = vc_base;
        vt_next = vt_base;
        bool_next = bool_reg;
        if (ctl.step)
        begin
            case (vc_base)
                VC_UNKNOWN, VC_NEG:
                begin
                    if (!ctl.ws)
                    begin
                        if (ctl.c == CH_ZERO)
                        begin
                            // a leading minus then zero reads as real
                            vc_next = VC_ZERO;
                            vt_next = (vc_base == VC_NEG) ? VK_REAL : VK_INT;
                        end
                        else if (dig)
                        begin
                            vc_next = VC_INT;
                            vt_next = VK_INT;
                        end
                        else if (vc_base == VC_UNKNOWN && ctl.c == CH_T)
                        begin
                            vc_next = VC_T;
                            vt_next = VK_STRING;
                        end
                        else if (vc_base == VC_UNKNOWN && ctl.c == CH_F)
                        begin
                            vc_next = VC_F;
                            vt_next = VK_STRING;
                        end
                        else if (vc_base == VC_UNKNOWN && ctl.c == CH_MINUS)
                        begin
                            vc_next = VC_NEG;
                            vt_next = VK_STRING;
                        end
                        else
                        begin
                            vc_next = VC_STRING;
                            vt_next = VK_STRING;
                        end
                    end
                end
                VC_INT, VC_ZERO:
                begin
                    if (ctl.ws)
                    begin
                        vc_next = VC_TRAIL;
                    end
                    else if (ctl.c == CH_DOT)
                    begin
                        vc_next = VC_REAL;
                        vt_next = VK_REAL;
                    end
                    else if (!dig)
                    begin
                        vc_next = VC_STRING;
                        vt_next = VK_STRING;
                    end
                end
                VC_REAL:
                begin
                    if (ctl.ws)
                    begin
                        vc_next = VC_TRAIL;
                    end
                    else if (!dig)
                    begin
                        vc_next = VC_STRING;
                        vt_next = VK_STRING;
                    end
                end
                VC_STRING:
                begin
                    if (ctl.ws)
                    begin
                        vc_next = VC_TRAIL;
                    end
                    else
                    begin
                        vt_next = VK_STRING;
                    end
                end
                // hold the spelling state on a byte that does not continue it
                VC_T:    if (ctl.c == CH_R) vc_next = VC_TR;
                VC_TR:   if (ctl.c == CH_U) vc_next = VC_TRU;
                VC_TRU:
                begin
                    if (ctl.c == CH_E)
                    begin
                        vc_next = VC_STRING;
                        vt_next = VK_BOOL;
                        bool_next = 1'b1;
                    end
                end
                VC_F:    if (ctl.c == CH_A) vc_next = VC_FA;
                VC_FA:   if (ctl.c == CH_L) vc_next = VC_FAL;
                VC_FAL:  if (ctl.c == CH_S) vc_next = VC_FALS;
                VC_FALS:
                begin
                    if (ctl.c == CH_E)
                    begin
                        vc_next = VC_STRING;
                        vt_next = VK_BOOL;
                        bool_next = 1'b0;
                    end
                end
                default:
                begin
                    if (!ctl.ws)
                    begin
                        vc_next = VC_STRING;
                        vt_next = VK_STRING;
                    end
                end
            endcase
        end
        if (ctl.clear)
        begin
            vc_next = VC_UNKNOWN;
            vt_next = VK_NULL;
            bool_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg   <= VC_UNKNOWN;
            vt_reg   <= VK_NULL;
            bool_reg <= 1'b0;
        end
        else
        begin
            vc_reg   <= vc_next;
            vt_reg   <= vt_next;
            bool_reg <= bool_next;
        end
    end

    assign stat.kind      = vt_reg;
    assign stat.bool_seen = bool_reg;

endmodule

// ===== hdl/ecsv_line_fsm.sv =====
// ----------------------------------------------------------------------------
// ecsv_line_fsm
// Row state, column and pair counts; builds the result words of each byte.
// ----------------------------------------------------------------------------
module ecsv_line_fsm #(
    parameter int LINE_MAX  = 1024,
    parameter int PAIRS_MAX = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            ch,
    input  ecsv_pkg::typer_stat_t tstat,
    output ecsv_pkg::typer_ctl_t  tctl,
    output logic [1:0]            push_cnt,
    output ecsv_pkg::result_t     res0,
    output ecsv_pkg::result_t     res1
);
    import ecsv_pkg::*;

    localparam int COL_W = $clog2(LINE_MAX);
    localparam int CNT_W = $clog2(PAIRS_MAX + 1);
    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(LINE_MAX - 1);
    localparam logic [CNT_W-1:0] PAIR_LIM  = CNT_W'(PAIRS_MAX);

    typedef enum logic [2:0] {
        RS_BEGIN,
        RS_NAME,
        RS_NDELIM,
        RS_TS,
        RS_KBEGIN,
        RS_KEY,
        RS_VBEGIN,
        RS_VAL
    } row_state_t;

    row_state_t       rs_reg, rs_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] fs_reg, fs_next;
    logic [COL_W-1:0] lk_reg, lk_next;
    logic [CNT_W-1:0] kc_reg, kc_next;
    logic [CNT_W-1:0] vc_reg, vc_next;
    logic             disc_reg, disc_next;

    logic [7:0]       c;
    logic             ws, dl, nl, semi, end_byte;
    logic             fld_v, st_v, start, step;
    token_kind_t      fld_kind;
    logic [COL_W:0]   fld_end;
    line_status_t     st_code;
    result_t          fld_res, st_res;

    always_comb
    begin
        end_byte = (ch == CH_LF) || (ch == CH_NUL);
        // NUL closes a timestamp or value like a newline
        c = (ch == CH_NUL && (rs_reg == RS_TS || rs_reg == RS_VAL)) ? CH_LF : ch;
        ws   = (c == CH_SPACE) || (c == CH_TAB);
        dl   = (c == CH_COMMA) || (c == CH_BAR);
        nl   = (c == CH_LF) || (c == CH_CR);
        semi = (c == CH_SEMI);

        rs_next   = rs_reg;
        col_next  = col_reg;
        fs_next   = fs_reg;
        lk_next   = lk_reg;
        kc_next   = kc_reg;
        vc_next   = vc_reg;
        disc_next = disc_reg;
        fld_v     = 1'b0;
        fld_kind  = KIND_NAME;
        fld_end   = {1'b0, lk_reg} + (COL_W + 1)'(1);
        st_v      = 1'b0;
        st_code   = ST_OK;
        start     = 1'b0;
        step      = 1'b0;

        if (accept)
        begin
            if (disc_reg)
            begin
                if (end_byte)
                    disc_next = 1'b0;
            end
            else
            begin
                if (c == CH_NUL)
                begin
                    st_v = 1'b1;
                    st_code = ST_UNEXPECTED_END;
                end
                else
                begin
                    case (rs_reg)
                        RS_BEGIN:
                        begin
                            if (!ws)
                            begin
                                rs_next = RS_NAME;
                                fs_next = col_reg;
                                lk_next = col_reg;
                            end
                        end
                        RS_NAME:
                        begin
                            if (dl)
                            begin
                                rs_next = RS_NDELIM;
                                fld_v = 1'b1;
                                fld_kind = KIND_NAME;
                            end
                            else if (!ws)
                            begin
                                lk_next = col_reg;
                            end
                        end
                        RS_NDELIM:
                        begin
                            if (!ws)
                            begin
                                rs_next = RS_TS;
                                fs_next = col_reg;
                            end
                        end
                        RS_TS:
                        begin
                            if (nl || dl)
                            begin
                                fld_v = 1'b1;
                                fld_kind = KIND_TS;
                                // timestamp span runs up to the closing byte
                                fld_end = {1'b0, col_reg};
                                if (nl)
                                    st_v = 1'b1;
                                else
                                    rs_next = RS_KBEGIN;
                            end
                        end
                        RS_KBEGIN:
                        begin
                            if (!ws)
                            begin
                                rs_next = RS_KEY;
                                fs_next = col_reg;
                                lk_next = col_reg;
                            end
                        end
                        RS_KEY:
                        begin
                            if (semi || dl)
                            begin
                                rs_next = semi ? RS_KBEGIN : RS_VBEGIN;
                                fld_v = 1'b1;
                                fld_kind = KIND_KEY;
                                kc_next = kc_reg + CNT_W'(1);
                            end
                            else if (!ws)
                            begin
                                lk_next = col_reg;
                            end
                        end
                        RS_VBEGIN:
                        begin
                            if (!dl && !ws)
                            begin
                                rs_next = RS_VAL;
                                start = 1'b1;
                                fs_next = col_reg;
                                lk_next = col_reg;
                            end
                        end
                        RS_VAL:
                        begin
                            if (semi || nl)
                            begin
                                fld_v = 1'b1;
                                fld_kind = KIND_VALUE;
                                vc_next = vc_reg + CNT_W'(1);
                                if (nl)
                                begin
                                    st_v = 1'b1;
                                    st_code = (kc_reg == vc_next) ? ST_OK
                                                                  : ST_COUNT_MISMATCH;
                                end
                                else
                                begin
                                    rs_next = RS_VBEGIN;
                                end
                            end
                            else if (!ws)
                            begin
                                lk_next = col_reg;
                            end
                        end
                        default:
                        begin
                            rs_next = RS_BEGIN;
                        end
                    endcase
                end

                step = !st_v && (rs_next == RS_VAL);

                if (!st_v && (kc_next == PAIR_LIM || vc_next == PAIR_LIM))
                begin
                    st_v = 1'b1;
                    st_code = ST_TOO_MANY_PAIRS;
                end
                if (!st_v && col_reg == LAST_COL)
                begin
                    st_v = 1'b1;
                    st_code = ST_TOO_LONG;
                end

                if (st_v)
                begin
                    // start the next line; drop the rest of this one unless it ended here
                    rs_next   = RS_BEGIN;
                    col_next  = '0;
                    fs_next   = '0;
                    lk_next   = '0;
                    kc_next   = '0;
                    vc_next   = '0;
                    disc_next = !end_byte;
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        fld_res = '0;
        fld_res.token_kind = fld_kind;
        fld_res.span_start = SPAN_START_W'(fs_reg);
        fld_res.span_end   = SPAN_END_W'(fld_end);
        fld_res.value_kind = VK_NULL;
        fld_res.line_status = ST_OK;
        if (fld_kind == KIND_VALUE)
        begin
            fld_res.value_kind = tstat.kind;
            fld_res.bool_value = (tstat.kind == VK_BOOL) ? tstat.bool_seen : 1'b0;
        end

        st_res = '0;
        st_res.token_kind  = KIND_STATUS;
        st_res.value_kind  = VK_NULL;
        st_res.line_status = st_code;
        st_res.last        = 1'b1;

        res0 = fld_v ? fld_res : st_res;
        res0.last = !(fld_v && st_v);
        res1 = st_res;
        push_cnt = {1'b0, fld_v} + {1'b0, st_v};

        tctl.clear = st_v;
        tctl.start = start;
        tctl.step  = step;
        tctl.c     = c;
        tctl.ws    = ws;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg   <= RS_BEGIN;
            col_reg  <= '0;
            fs_reg   <= '0;
            lk_reg   <= '0;
            kc_reg   <= '0;
            vc_reg   <= '0;
            disc_reg <= 1'b0;
        end
        else
        begin
            rs_reg   <= rs_next;
            col_reg  <= col_next;
            fs_reg   <= fs_next;
            lk_reg   <= lk_next;
            kc_reg   <= kc_next;
            vc_reg   <= vc_next;
            disc_reg <= disc_next;
        end
    end

endmodule

// ===== hdl/ecsv_result_fifo.sv =====
// ----------------------------------------------------------------------------
// ecsv_result_fifo
// Small result queue: takes up to two words a cycle, hands out one.
// ----------------------------------------------------------------------------
module ecsv_result_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [1:0]                     push_cnt,
    input  ecsv_pkg::result_t              res0,
    input  ecsv_pkg::result_t              res1,
    input  logic                           pop,
    output ecsv_pkg::result_t              head,
    output logic [$clog2(ecsv_pkg::FIFO_DEPTH+1)-1:0] level
);
    import ecsv_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

    result_t          mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, wr_inc;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;

    always_comb
    begin
        wr_inc   = wr_reg + PTR_W'(1);
        wr_next  = wr_reg + PTR_W'(push_cnt);
        rd_next  = pop ? rd_reg + PTR_W'(1) : rd_reg;
        lvl_next = lvl_reg + LVL_W'(push_cnt) - LVL_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem[wr_reg] <= res0;
        if (push_cnt == 2'd2)
            mem[wr_inc] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            lvl_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            lvl_reg <= lvl_next;
        end
    end

    assign head  = mem[rd_reg];
    assign level = lvl_reg;

endmodule

// ===== hdl/event_csv_line_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// event_csv_line_tokenizer_top
// Event log line tokenizer: field spans, value types and line status.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the queue has room and updates
// its row and value-type state in the same cycle. A byte yields zero, one
// or two words (a field closing and a line status), which are registered
// into a four-word result queue; the queue hands out one word a cycle while
// the output is ready, so bytes are taken every cycle while at most two
// words are waiting. The two words of a byte leave in order, field first.
// No clearing pass follows reset.
module event_csv_line_tokenizer_top #(
    parameter int LINE_MAX  = 1024,
    parameter int PAIRS_MAX = 16
) (
    input logic       clk,
    input logic       rst_n,
    ecsv_in_if.sink   chars,
    ecsv_out_if.source tokens
);
    import ecsv_pkg::*;

    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

    logic             accept, pop;
    logic [1:0]       push_cnt;
    logic [LVL_W-1:0] level;
    result_t          res0, res1, head;
    typer_ctl_t       tctl;
    typer_stat_t      tstat;

    assign chars.ready = (level <= LVL_W'(FIFO_DEPTH - 2));
    assign accept      = chars.valid && chars.ready;

    ecsv_line_fsm #(
        .LINE_MAX  (LINE_MAX),
        .PAIRS_MAX (PAIRS_MAX)
    ) u_line (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .ch       (chars.ch),
        .tstat    (tstat),
        .tctl     (tctl),
        .push_cnt (push_cnt),
        .res0     (res0),
        .res1     (res1)
    );

    ecsv_value_typer u_typer (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (tctl),
        .stat  (tstat)
    );

    ecsv_result_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .res0     (res0),
        .res1     (res1),
        .pop      (pop),
        .head     (head),
        .level    (level)
    );

    assign tokens.valid       = (level != '0);
    assign pop                = tokens.valid && tokens.ready;
    assign tokens.token_kind  = head.token_kind;
    assign tokens.span_start  = head.span_start;
    assign tokens.span_end    = head.span_end;
    assign tokens.value_kind  = head.value_kind;
    assign tokens.bool_value  = head.bool_value;
    assign tokens.line_status = head.line_status;
    assign tokens.last        = head.last;

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= LVL_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        tokens.valid && tokens.token_kind == KIND_STATUS |->
            tokens.last && tokens.span_start == '0 && tokens.span_end == '0)
        else $error("status word malformed");

    a_non_value_plain: assert property (@(posedge clk) disable iff (!rst_n)
        tokens.valid && tokens.token_kind != KIND_VALUE |->
            tokens.value_kind == VK_NULL && !tokens.bool_value)
        else $error("value type on a non-value word");

    a_two_word_pair: assert property (@(posedge clk) disable iff (!rst_n)
        tokens.valid && !tokens.last |-> tokens.token_kind != KIND_STATUS && level >= LVL_W'(2))
        else $error("field word without its status behind it");
`endif

endmodule
